>>> rtl/mr16exu_pkg.sv
// Shared types, constants and helper functions for the mini RISC16 execute unit.
`timescale 1ns / 1ps

package mr16exu_pkg;

  // Sizes of the architectural state. DATA_DEPTH must be a power of two.
  localparam int WORD_WIDTH = 32;
  localparam int DATA_DEPTH = 256;
  localparam int REG_COUNT  = 8;
  localparam int REG_AW     = $clog2(REG_COUNT);
  localparam int DM_AW      = $clog2(DATA_DEPTH);
  localparam int PC_W       = 8;
  localparam int EXT_W      = 32;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [REG_AW-1:0]     reg_idx_t;
  typedef logic [DM_AW-1:0]      dm_addr_t;
  typedef logic [PC_W-1:0]       pc_t;

  // Access codes carried by each input word.
  localparam logic [1:0] ACC_EXEC = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_READ = 2'd2;
  localparam logic [1:0] ACC_NONE = 2'd3;

  // Instruction opcodes.
  localparam logic [3:0] OPC_RTYPE = 4'd0;
  localparam logic [3:0] OPC_J     = 4'd2;
  localparam logic [3:0] OPC_ADDI  = 4'd4;
  localparam logic [3:0] OPC_BEQ   = 4'd8;
  localparam logic [3:0] OPC_LW    = 4'd11;
  localparam logic [3:0] OPC_SW    = 4'd15;

  // Function codes of register-register instructions.
  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_AND = 3'd4;
  localparam logic [2:0] FN_OR  = 3'd5;

  // Sign-extends the 6-bit immediate to the word width.
  function automatic word_t imm_ext(input logic [15:0] instr);
    return word_t'($signed(instr[5:0]));
  endfunction

  // Maps an 8-bit byte address onto a data memory index.
  function automatic dm_addr_t dm_index(input logic [7:0] a);
    logic [DM_AW+7:0] t;
    t = {{DM_AW{1'b0}}, a};
    return t[DM_AW-1:0];
  endfunction

  // Zero-extends or truncates a machine word to the 32-bit port width.
  function automatic logic [EXT_W-1:0] to_ext(input word_t w);
    logic [WORD_WIDTH+EXT_W-1:0] t;
    t = {{EXT_W{1'b0}}, w};
    return t[EXT_W-1:0];
  endfunction

  // Sign-extends or truncates a 32-bit port value to the machine word.
  function automatic word_t from_ext(input logic [EXT_W-1:0] v);
    logic [WORD_WIDTH+EXT_W-1:0] t;
    t = {{WORD_WIDTH{v[EXT_W-1]}}, v};
    return t[WORD_WIDTH-1:0];
  endfunction

endpackage

>>> rtl/mr16exu_if.sv
// Handshake interfaces for the request and response channels of the execute unit.
`timescale 1ns / 1ps

interface mr16exu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [15:0]        instruction_word;
  logic [7:0]         data_address;
  logic signed [31:0] data_value;

  modport source(output valid, opcode, instruction_word, data_address, data_value,
                 input ready);
  modport sink(input valid, opcode, instruction_word, data_address, data_value,
               output ready);
endinterface

interface mr16exu_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         next_pc;
  logic               reg_write_valid;
  logic [2:0]         reg_write_index;
  logic signed [31:0] reg_write_value;
  logic               mem_write_valid;
  logic [7:0]         mem_write_address;
  logic signed [31:0] mem_write_value;
  logic signed [31:0] read_data;

  modport source(output valid, next_pc, reg_write_valid, reg_write_index, reg_write_value,
                 mem_write_valid, mem_write_address, mem_write_value, read_data,
                 input ready);
  modport sink(input valid, next_pc, reg_write_valid, reg_write_index, reg_write_value,
               mem_write_valid, mem_write_address, mem_write_value, read_data,
               output ready);
endinterface

>>> rtl/mr16exu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module mr16exu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the entry being written returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/mini_risc16_execute_unit_core.sv
// Top level of the mini RISC16 execute unit: register read, execute, memory access.
`timescale 1ns / 1ps

// Channel | Dir | Handshake     | Word contents
// req     | in  | valid / ready | opcode, instruction_word, data_address, data_value
// rsp     | out | valid / ready | next_pc, register write, memory write, read_data
//
// Each word passes through a register read stage, which reads the register file RAMs, and
// a memory stage, which reads the data memory RAM; a new word can be taken every cycle
// while the response is not stalled; a load needs that data memory read before writeback.
// Reset clears the pc, the valid bits of both memories and the pipeline; no clearing pass.
// A stalled response holds the whole pipeline; the first stage still fills while it waits.

module mini_risc16_execute_unit_core (
  input logic            clk,
  input logic            rst,
  mr16exu_in_if.sink     req,
  mr16exu_out_if.source  rsp
);

  import mr16exu_pkg::*;

  // Pipeline control.
  logic en2;
  logic s1_move;
  logic accept;
  logic wb_en;

  // First stage: word under register read.
  logic          s1_valid;
  logic [1:0]    s1_op;
  logic [15:0]   s1_instr;
  logic [7:0]    s1_addr;
  logic [31:0]   s1_value;
  logic          s1_va;
  logic          s1_vb;
  logic          s1_fa_hit;
  logic          s1_fb_hit;
  word_t         s1_fa;
  word_t         s1_fb;

  // Second stage: word under data memory read, also the output register.
  logic          s2_valid;
  pc_t           s2_pc;
  logic          s2_rv;
  reg_idx_t      s2_ri;
  word_t         s2_rval;
  logic          s2_is_lw;
  logic          s2_is_rd;
  logic          s2_mv;
  dm_addr_t      s2_ma;
  word_t         s2_mval;

  // Architectural state outside the RAMs.
  pc_t                  pc;
  logic [REG_COUNT-1:0] reg_valid;
  logic [DATA_DEPTH-1:0] dm_valid;
  logic                 dm_vq;

  // RAM ports.
  word_t    rf_a_q;
  word_t    rf_b_q;
  word_t    dm_q;
  reg_idx_t rs_in;
  reg_idx_t rt_in;
  dm_addr_t dm_raddr;
  logic     dm_we;

  // Decoded first-stage values.
  logic [3:0] opc;
  reg_idx_t   f_rs;
  reg_idx_t   f_rt;
  reg_idx_t   f_rd;
  logic [2:0] fn;
  word_t      imm;
  word_t      a_base;
  word_t      b_base;
  word_t      a;
  word_t      b;
  word_t      sum_ai;
  dm_addr_t   ea;
  logic       is_exec;
  logic       is_rtype;
  pc_t        pc_new;
  pc_t        pc_out;
  logic       n_rv;
  reg_idx_t   n_ri;
  word_t      n_rval;
  logic       n_is_lw;
  logic       n_is_rd;
  logic       n_mv;
  dm_addr_t   n_ma;
  word_t      n_mval;

  // Writeback value of the word in the second stage.
  word_t dm_word;
  word_t wb_val;

  // Handshake and stage enables.
  assign en2     = !s2_valid || rsp.ready;
  assign s1_move = s1_valid && en2;
  assign req.ready = !s1_valid || en2;
  assign accept  = req.valid && req.ready;
  assign wb_en   = s2_valid && rsp.ready && s2_rv;

  assign rs_in = req.instruction_word[11:9];
  assign rt_in = req.instruction_word[8:6];

  // Second-stage result: a load takes the word just read from data memory.
  assign dm_word = dm_vq ? dm_q : '0;
  assign wb_val  = s2_is_lw ? dm_word : s2_rval;

  // Register file: two copies, one per read port, written together at writeback.
  mr16exu_ram #(.WIDTH(WORD_WIDTH), .DEPTH(REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (wb_en),
    .waddr (s2_ri),
    .wdata (wb_val),
    .re    (accept),
    .raddr (rs_in),
    .rdata (rf_a_q)
  );

  mr16exu_ram #(.WIDTH(WORD_WIDTH), .DEPTH(REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (wb_en),
    .waddr (s2_ri),
    .wdata (wb_val),
    .re    (accept),
    .raddr (rt_in),
    .rdata (rf_b_q)
  );

  // Data memory, read and written when a word leaves the first stage.
  assign dm_we = s1_move && n_mv;

  mr16exu_ram #(.WIDTH(WORD_WIDTH), .DEPTH(DATA_DEPTH)) u_dm (
    .clk   (clk),
    .we    (dm_we),
    .waddr (n_ma),
    .wdata (n_mval),
    .re    (s1_move),
    .raddr (dm_raddr),
    .rdata (dm_q)
  );

  // Instruction fields of the first-stage word.
  assign opc  = s1_instr[15:12];
  assign f_rs = s1_instr[11:9];
  assign f_rt = s1_instr[8:6];
  assign f_rd = s1_instr[5:3];
  assign fn   = s1_instr[2:0];
  assign imm  = imm_ext(s1_instr);

  // Operands: RAM data, the write that coincided with the read, then the older word ahead.
  assign a_base = s1_fa_hit ? s1_fa : (s1_va ? rf_a_q : '0);
  assign b_base = s1_fb_hit ? s1_fb : (s1_vb ? rf_b_q : '0);
  assign a = (s2_valid && s2_rv && (s2_ri == f_rs)) ? wb_val : a_base;
  assign b = (s2_valid && s2_rv && (s2_ri == f_rt)) ? wb_val : b_base;

  assign sum_ai   = a + imm;
  assign ea       = dm_index(sum_ai[7:0]);
  assign is_exec  = (s1_op == ACC_EXEC);
  assign is_rtype = (opc == OPC_RTYPE) &&
                    ((fn == FN_ADD) || (fn == FN_SUB) || (fn == FN_AND) || (fn == FN_OR));
  assign dm_raddr = n_is_lw ? ea : dm_index(s1_addr);

  // Execute: register result, memory write and next pc of the first-stage word.
  always_comb begin
    n_rv    = 1'b0;
    n_ri    = '0;
    n_rval  = '0;
    n_is_lw = 1'b0;
    n_is_rd = 1'b0;
    n_mv    = 1'b0;
    n_ma    = '0;
    n_mval  = '0;
    pc_new  = pc;
    case (s1_op)
      ACC_EXEC: begin
        if (is_rtype) begin
          n_rv = 1'b1;
          n_ri = f_rd;
          case (fn)
            FN_ADD:  n_rval = a + b;
            FN_SUB:  n_rval = a - b;
            FN_AND:  n_rval = a & b;
            default: n_rval = a | b;
          endcase
        end else begin
          case (opc)
            OPC_ADDI: begin
              n_rv   = 1'b1;
              n_ri   = f_rt;
              n_rval = sum_ai;
            end
            OPC_LW: begin
              n_rv    = 1'b1;
              n_ri    = f_rt;
              n_is_lw = 1'b1;
            end
            OPC_SW: begin
              n_mv   = 1'b1;
              n_ma   = ea;
              n_mval = b;
            end
            OPC_BEQ: begin
              if (a == b) begin
                pc_new = pc + imm[PC_W-1:0];
              end
            end
            OPC_J: begin
              pc_new = {1'b0, s1_instr[6:0]};
            end
            default: begin
            end
          endcase
        end
        if (pc_new == pc) begin
          pc_new = pc + pc_t'(1);
        end
      end
      ACC_LOAD: begin
        n_mv   = 1'b1;
        n_ma   = dm_index(s1_addr);
        n_mval = from_ext(s1_value);
      end
      ACC_READ: begin
        n_is_rd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign pc_out = is_exec ? pc_new : pc;

  // Control state: stage valid flags, pc and memory valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      pc        <= '0;
      reg_valid <= '0;
      dm_valid  <= '0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (s1_move && is_exec) begin
        pc <= pc_new;
      end
      if (wb_en) begin
        reg_valid[s2_ri] <= 1'b1;
      end
      if (dm_we) begin
        dm_valid[n_ma] <= 1'b1;
      end
    end
  end

  // First-stage payload, with the writeback that happens at the same edge captured.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= req.opcode;
      s1_instr  <= req.instruction_word;
      s1_addr   <= req.data_address;
      s1_value  <= req.data_value;
      s1_va     <= reg_valid[rs_in];
      s1_vb     <= reg_valid[rt_in];
      s1_fa_hit <= wb_en && (s2_ri == rs_in);
      s1_fb_hit <= wb_en && (s2_ri == rt_in);
      s1_fa     <= wb_val;
      s1_fb     <= wb_val;
    end
  end

  // Second-stage payload.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_pc    <= pc_out;
      s2_rv    <= n_rv;
      s2_ri    <= n_ri;
      s2_rval  <= n_rval;
      s2_is_lw <= n_is_lw;
      s2_is_rd <= n_is_rd;
      s2_mv    <= n_mv;
      s2_ma    <= n_ma;
      s2_mval  <= n_mval;
      dm_vq    <= dm_valid[dm_raddr];
    end
  end

  // Response word.
  assign rsp.valid             = s2_valid;
  assign rsp.next_pc           = s2_pc;
  assign rsp.reg_write_valid   = s2_rv;
  assign rsp.reg_write_index   = s2_ri;
  assign rsp.reg_write_value   = to_ext(wb_val);
  assign rsp.mem_write_valid   = s2_mv;
  assign rsp.mem_write_address = dm_index(8'd0) | s2_ma;
  assign rsp.mem_write_value   = to_ext(s2_mval);
  assign rsp.read_data         = s2_is_rd ? to_ext(dm_word) : '0;

  // A word never writes both the register file and the data memory.
  assert property (@(posedge clk) disable iff (rst)
    !(s2_valid && s2_rv && s2_mv))
    else $error("register and memory write in one word");

  // The pc only moves when an executed word leaves the first stage.
  assert property (@(posedge clk) disable iff (rst)
    !(s1_move && is_exec) |=> $stable(pc))
    else $error("pc changed without an executed word");

  // A word waiting in the first stage is not lost while the output stalls.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !en2 |=> s1_valid && $stable(s1_instr))
    else $error("first stage dropped a waiting word");

  // Data read out of memory holds while the response is stalled.
  assert property (@(posedge clk) disable iff (rst)
    s2_valid && !rsp.ready |=> $stable(dm_word) && $stable(dm_vq))
    else $error("data memory output changed under a stalled response");

  // Only a read access returns data.
  assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_is_rd |-> rsp.read_data == '0)
    else $error("read data on a word that is not a read access");

endmodule

>>> sim/mini_risc16_execute_unit_core_tb.sv
// Self-checking testbench for the mini RISC16 execute unit core.
`timescale 1ns / 1ps

module mini_risc16_execute_unit_core_tb;
  import mr16exu_pkg::*;

  localparam int         CYCLE_LIMIT = 400000;
  localparam int         HOLD_CYCLES = 80;
  localparam logic [3:0] OPC_UNUSED  = 4'd1;
  localparam logic [2:0] FN_UNUSED   = 3'd7;

  // One request word and one response word, field for field as on the channels.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] instruction_word;
    logic [7:0]  data_address;
    logic [31:0] data_value;
  } req_word_t;

  typedef struct packed {
    logic [7:0]  next_pc;
    logic        reg_write_valid;
    logic [2:0]  reg_write_index;
    logic [31:0] reg_write_value;
    logic        mem_write_valid;
    logic [7:0]  mem_write_address;
    logic [31:0] mem_write_value;
    logic [31:0] read_data;
  } rsp_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mr16exu_in_if  req_if ();
  mr16exu_out_if rsp_if ();

  mini_risc16_execute_unit_core i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // Architectural state as the testbench sees it.
  word_t gpr [REG_COUNT];
  word_t dmem [DATA_DEPTH];
  pc_t   cur_pc;

  rsp_word_t retire_q[$];
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  bit        idle_on = 1'b1;
  bit        hold_toggle = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Runs one word against the architectural state and returns the response it must produce.
  function automatic rsp_word_t arch_step(input req_word_t w);
    rsp_word_t  r;
    logic [3:0] opc;
    reg_idx_t   rs, rt, rd;
    logic [2:0] fn;
    word_t      a, b, imm, sum, alu;
    pc_t        npc;
    dm_addr_t   ea;
    r   = '0;
    opc = w.instruction_word[15:12];
    rs  = w.instruction_word[11:9];
    rt  = w.instruction_word[8:6];
    rd  = w.instruction_word[5:3];
    fn  = w.instruction_word[2:0];
    a   = gpr[rs];
    b   = gpr[rt];
    imm = {{(WORD_WIDTH-6){w.instruction_word[5]}}, w.instruction_word[5:0]};
    sum = a + imm;
    // The effective address is the low byte of base plus offset.
    ea  = sum[7:0];
    case (w.opcode)
      ACC_EXEC: begin
        npc = cur_pc;
        case (opc)
          OPC_RTYPE: begin
            case (fn)
              FN_ADD:  alu = a + b;
              FN_SUB:  alu = a - b;
              FN_AND:  alu = a & b;
              default: alu = a | b;
            endcase
            if (fn == FN_ADD || fn == FN_SUB || fn == FN_AND || fn == FN_OR) begin
              r.reg_write_valid = 1'b1;
              r.reg_write_index = rd;
              r.reg_write_value = alu;
            end
          end
          OPC_ADDI: begin
            r.reg_write_valid = 1'b1;
            r.reg_write_index = rt;
            r.reg_write_value = sum;
          end
          OPC_LW: begin
            r.reg_write_valid = 1'b1;
            r.reg_write_index = rt;
            r.reg_write_value = dmem[ea];
          end
          OPC_SW: begin
            r.mem_write_valid   = 1'b1;
            r.mem_write_address = ea;
            r.mem_write_value   = b;
            dmem[ea] = b;
          end
          OPC_BEQ: begin
            if (a == b) npc = cur_pc + imm[7:0];
          end
          OPC_J: npc = {1'b0, w.instruction_word[6:0]};
          default: ;
        endcase
        if (r.reg_write_valid) gpr[r.reg_write_index] = r.reg_write_value;
        // A pc left where it was still steps forward by one.
        cur_pc = (npc == cur_pc) ? pc_t'(cur_pc + 8'd1) : npc;
      end
      ACC_LOAD: begin
        r.mem_write_valid   = 1'b1;
        r.mem_write_address = w.data_address;
        r.mem_write_value   = w.data_value;
        dmem[w.data_address] = w.data_value;
      end
      ACC_READ: r.read_data = dmem[w.data_address];
      default: ;
    endcase
    r.next_pc = cur_pc;
    return r;
  endfunction

  function automatic logic [15:0] encode(input logic [3:0] opc, input logic [2:0] s,
                                         input logic [2:0] t, input logic [5:0] low);
    return {opc, s, t, low};
  endfunction

  function automatic req_word_t mk(input logic [1:0] op, input logic [15:0] instr,
                                   input logic [7:0] addr, input logic [31:0] value);
    req_word_t w;
    w.opcode           = op;
    w.instruction_word = instr;
    w.data_address     = addr;
    w.data_value       = value;
    return w;
  endfunction

  // Mostly well-formed instructions with random operands, plus raw words and data accesses.
  function automatic req_word_t random_word();
    req_word_t  w;
    int         pick;
    logic [2:0] s, t, d, fn;
    logic [5:0] low;
    w = mk(ACC_EXEC, 16'($urandom), 8'($urandom), $urandom);
    case ($urandom_range(0, 15))
      0: w.data_value = 32'h8000_0000;
      1: w.data_value = 32'h7FFF_FFFF;
      2: w.data_value = 32'hFFFF_FFFF;
      3: w.data_value = 32'h0000_0000;
      default: ;
    endcase
    s    = 3'($urandom);
    t    = 3'($urandom);
    d    = 3'($urandom);
    low  = 6'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      w.opcode = ACC_LOAD;
    end else if (pick < 17) begin
      w.opcode = ACC_READ;
    end else if (pick < 19) begin
      w.opcode = ACC_NONE;
    end else if (pick >= 23) begin
      case ($urandom_range(0, 4))
        0:       fn = FN_ADD;
        1:       fn = FN_SUB;
        2:       fn = FN_AND;
        3:       fn = FN_OR;
        default: fn = 3'($urandom);
      endcase
      case ($urandom_range(0, 9))
        2, 3:    w.instruction_word = encode(OPC_ADDI, s, t, low);
        4:       w.instruction_word = encode(OPC_LW, s, t, low);
        5:       w.instruction_word = encode(OPC_SW, s, t, low);
        6:       w.instruction_word = encode(OPC_BEQ, s, s, low);
        7:       w.instruction_word = encode(OPC_BEQ, s, t, low);
        8:       w.instruction_word = encode(OPC_J, s, t, low);
        default: w.instruction_word = encode(OPC_RTYPE, s, t, {d, fn});
      endcase
    end
    return w;
  endfunction

  // Offers one word from the falling edge on and returns at the edge that takes it.
  task automatic send_word(input req_word_t w);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid            <= 1'b1;
    req_if.opcode           <= w.opcode;
    req_if.instruction_word <= w.instruction_word;
    req_if.data_address     <= w.data_address;
    req_if.data_value       <= w.data_value;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    retire_q.push_back(arch_step(w));
  endtask

  // Field extremes, every instruction, address and pc wrap, unknown codes.
  task automatic test_directed();
    send_word(mk(ACC_LOAD, 16'h0000, 8'd0, 32'h7FFF_FFFF));
    send_word(mk(ACC_LOAD, 16'h0000, 8'd255, 32'h8000_0000));
    send_word(mk(ACC_READ, 16'h0000, 8'd255, 32'h0));
    send_word(mk(ACC_READ, 16'h0000, 8'd0, 32'h0));
    // A word never written reads back as zero.
    send_word(mk(ACC_READ, 16'h0000, 8'd17, 32'h0));
    send_word(mk(ACC_EXEC, encode(OPC_ADDI, 3'd0, 3'd1, 6'd31), 8'd0, 32'h0));
    // A jump to the current pc still advances it.
    send_word(mk(ACC_EXEC, {OPC_J, 5'd0, cur_pc[6:0]}, 8'd0, 32'h0));
    // A taken branch backwards from a low pc wraps around zero.
    send_word(mk(ACC_EXEC, encode(OPC_BEQ, 3'd4, 3'd4, 6'h20), 8'd0, 32'h0));
    send_word(mk(ACC_EXEC, encode(OPC_ADDI, 3'd0, 3'd2, 6'h20), 8'd0, 32'h0));
    send_word(mk(ACC_EXEC, encode(OPC_RTYPE, 3'd1, 3'd2, {3'd3, FN_ADD}), 8'd0, 32'h0));
    send_word(mk(ACC_EXEC, encode(OPC_RTYPE, 3'd2, 3'd1, {3'd4, FN_SUB}), 8'd0, 32'h0));
    send_word(mk(ACC_EXEC, encode(OPC_RTYPE, 3'd2, 3'd1, {3'd5, FN_AND}), 8'd0, 32'h0));
    send_word(mk(ACC_EXEC, encode(OPC_RTYPE, 3'd2, 3'd1, {3'd6, FN_OR}), 8'd0, 32'h0));
    // Register 0 takes a load; the base plus offset lands on the top byte.
    send_word(mk(ACC_EXEC, encode(OPC_LW, 3'd2, 3'd0, 6'd31), 8'd0, 32'h0));
    send_word(mk(ACC_EXEC, encode(OPC_RTYPE, 3'd0, 3'd0, {3'd7, FN_ADD}), 8'd0, 32'h0));
    send_word(mk(ACC_EXEC, encode(OPC_ADDI, 3'd0, 3'd6, 6'h3F), 8'd0, 32'h0));
    send_word(mk(ACC_EXEC, encode(OPC_SW, 3'd2, 3'd1, 6'd31), 8'd0, 32'h0));
    send_word(mk(ACC_EXEC, encode(OPC_LW, 3'd1, 3'd5, 6'h20), 8'd0, 32'h0));
    // A taken branch with a zero offset still advances the pc.
    send_word(mk(ACC_EXEC, encode(OPC_BEQ, 3'd7, 3'd7, 6'd0), 8'd0, 32'h0));
    send_word(mk(ACC_EXEC, encode(OPC_BEQ, 3'd3, 3'd3, 6'h3B), 8'd0, 32'h0));
    send_word(mk(ACC_EXEC, encode(OPC_BEQ, 3'd1, 3'd2, 6'd10), 8'd0, 32'h0));
    send_word(mk(ACC_EXEC, {OPC_J, 5'd0, 7'h7F}, 8'd0, 32'h0));
    send_word(mk(ACC_EXEC, {OPC_UNUSED, 12'hABC}, 8'd0, 32'h0));
    send_word(mk(ACC_EXEC, encode(OPC_RTYPE, 3'd1, 3'd2, {3'd3, FN_UNUSED}), 8'd0, 32'h0));
    send_word(mk(ACC_NONE, 16'hFFFF, 8'd255, 32'hFFFF_FFFF));
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_word(random_word());
  endtask

  // The response side holds off for a long stretch while words keep coming.
  task automatic test_backpressure();
    idle_on = 1'b0;
    send_word(random_word());
    hold_toggle = ~hold_toggle;
    repeat (60) send_word(random_word());
    idle_on = 1'b1;
  endtask

  task automatic test_steady_stream(input int count);
    idle_on = 1'b0;
    repeat (count) send_word(random_word());
  endtask

  // Response ready: random stall bursts, plus a long hold when one is requested.
  initial begin : rsp_ready_drive
    bit hold_seen;
    int hold_left;
    int stall_left;
    hold_seen  = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_val, act_val);
      err_cnt++;
    end
  endfunction

  // Each response word is compared with the oldest expected one.
  always @(posedge clk) begin : result_check
    rsp_word_t exp_word;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (retire_q.size() == 0) begin
        $error("response word with none expected, next_pc 0x%02h", rsp_if.next_pc);
        err_cnt++;
      end else begin
        exp_word = retire_q.pop_front();
        check_field("next_pc", 32'(exp_word.next_pc), 32'(rsp_if.next_pc));
        check_field("reg_write_valid", 32'(exp_word.reg_write_valid),
                    32'(rsp_if.reg_write_valid));
        check_field("reg_write_index", 32'(exp_word.reg_write_index),
                    32'(rsp_if.reg_write_index));
        check_field("reg_write_value", exp_word.reg_write_value, rsp_if.reg_write_value);
        check_field("mem_write_valid", 32'(exp_word.mem_write_valid),
                    32'(rsp_if.mem_write_valid));
        check_field("mem_write_address", 32'(exp_word.mem_write_address),
                    32'(rsp_if.mem_write_address));
        check_field("mem_write_value", exp_word.mem_write_value, rsp_if.mem_write_value);
        check_field("read_data", exp_word.read_data, rsp_if.read_data);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    req_if.valid            <= 1'b0;
    req_if.opcode           <= ACC_EXEC;
    req_if.instruction_word <= '0;
    req_if.data_address     <= '0;
    req_if.data_value       <= '0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    cur_pc = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix(1500);
    test_backpressure();
    test_steady_stream(170);

    @(negedge clk);
    req_if.valid <= 1'b0;
    while (retire_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
